// ----- design/pfa_pkg.sv -----
// Package for the page frame allocator: frame geometry, field widths,
// register defaults and the result record. No dependencies.
package pfa_pkg;

    localparam int NUM_FRAMES = 64;
    localparam int FRAME_W    = $clog2(NUM_FRAMES);
    localparam int CNT_W      = FRAME_W + 1;
    localparam int OWNER_W    = 12;
    localparam int ADDR_W     = 32;
    localparam int PAGE_SHIFT = 12;
    localparam int VPN_W      = ADDR_W - PAGE_SHIFT;
    localparam int FLAGS_W    = 6;
    localparam int SEL_W      = 6;
    localparam int PTE_WORD_W = VPN_W + FLAGS_W;
    localparam int PADDR_W    = 3;

    localparam logic [ADDR_W-1:0] BASE_RESET = 32'hA090_8000;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_BIND  = 1'b1;

    localparam logic REG_FRAME_BASE = 1'b0;

    typedef struct packed {
        logic [FRAME_W-1:0]    frame_no;
        logic                  evicted;
        logic                  no_frame;
        logic [VPN_W-1:0]      pte_index;
        logic [PTE_WORD_W-1:0] pte_word;
        logic [ADDR_W-1:0]     tlb_entry_hi;
    } t_result;

endpackage

// ----- design/pfa_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module pfa_ram #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 8,
    parameter int AW     = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/page_frame_allocator_fifo_unit.sv -----
// Page frame allocator with FIFO replacement: top level, built on pfa_pkg and pfa_ram.
// The result is registered in the output register from the S_EMIT state; an allocation that
// evicts a frame passes through S_RING first (ring read, then owner read). One transaction is
// processed at a time: a new one is not accepted until the last has left S_EMIT, which waits
// while the output is stalled. Reset clears the used-frame count, the ring pointers,
// the base register and the output valid; the owner and ring memories need no clearing.
module page_frame_allocator_fifo_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_action,
    input  logic                           i_pinned,
    input  logic [pfa_pkg::SEL_W-1:0]      i_frame_sel,
    input  logic [pfa_pkg::ADDR_W-1:0]     i_virt_addr,
    input  logic [pfa_pkg::OWNER_W-1:0]    i_owner_id,
    input  logic [pfa_pkg::FLAGS_W-1:0]    i_pte_flags,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [pfa_pkg::FRAME_W-1:0]    o_frame_no,
    output logic                           o_evicted,
    output logic [pfa_pkg::OWNER_W-1:0]    o_victim_owner,
    output logic                           o_no_frame,
    output logic [pfa_pkg::VPN_W-1:0]      o_pte_index,
    output logic [pfa_pkg::PTE_WORD_W-1:0] o_pte_word,
    output logic [pfa_pkg::ADDR_W-1:0]     o_tlb_entry_hi,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pfa_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import pfa_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RING = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_next_free, n_next_free;
    logic [FRAME_W-1:0] r_head, n_head;
    logic [FRAME_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_pinned, n_pinned;
    t_result            r_res, n_res;
    logic [ADDR_W-1:0]  r_base;

    logic               r_o_valid;
    t_result            r_out;
    logic [OWNER_W-1:0] r_o_victim;

    logic               accept;
    logic               out_free;
    logic               cfg_wr;

    logic               ring_wr_en;
    logic [FRAME_W-1:0] ring_wr_addr;
    logic [FRAME_W-1:0] ring_wr_data;
    logic [FRAME_W-1:0] ring_q;
    logic               own_wr_en;
    logic [OWNER_W-1:0] owner_q;
    logic [VPN_W-1:0]   frame_pfn;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !r_o_valid || !i_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_FRAME_BASE) ? r_base : 32'd0;

    assign frame_pfn = r_base[ADDR_W-1:PAGE_SHIFT]
                     + VPN_W'(i_frame_sel[FRAME_W-1:0]);

    assign own_wr_en = accept && (i_action == ACT_BIND);

    pfa_ram #(
        .DEPTH  (NUM_FRAMES),
        .DATA_W (FRAME_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (ring_wr_en),
        .i_wr_addr (ring_wr_addr),
        .i_wr_data (ring_wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (r_head),
        .o_rd_data (ring_q)
    );

    pfa_ram #(
        .DEPTH  (NUM_FRAMES),
        .DATA_W (OWNER_W)
    ) u_owner (
        .i_clk     (i_clk),
        .i_wr_en   (own_wr_en),
        .i_wr_addr (i_frame_sel[FRAME_W-1:0]),
        .i_wr_data (i_owner_id),
        .i_rd_en   (r_state == S_RING),
        .i_rd_addr (ring_q),
        .o_rd_data (owner_q)
    );

    always_comb begin
        n_state      = r_state;
        n_next_free  = r_next_free;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_pinned     = r_pinned;
        n_res        = r_res;
        ring_wr_en   = 1'b0;
        ring_wr_addr = r_tail;
        ring_wr_data = r_next_free[FRAME_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res    = '0;
                    n_pinned = i_pinned;
                    if (i_action == ACT_BIND) begin
                        n_res.frame_no     = i_frame_sel[FRAME_W-1:0];
                        n_res.pte_index    = i_virt_addr[ADDR_W-1:PAGE_SHIFT];
                        n_res.pte_word     = {frame_pfn, i_pte_flags};
                        n_res.tlb_entry_hi = {i_virt_addr[ADDR_W-1:PAGE_SHIFT], i_owner_id};
                        n_state            = S_EMIT;
                    end else if (!r_next_free[FRAME_W]) begin
                        n_res.frame_no = r_next_free[FRAME_W-1:0];
                        n_next_free    = r_next_free + CNT_W'(1);
                        if (!i_pinned && (r_count < CNT_W'(NUM_FRAMES))) begin
                            ring_wr_en = 1'b1;
                            n_tail     = r_tail + FRAME_W'(1);
                            n_count    = r_count + CNT_W'(1);
                        end
                        n_state = S_EMIT;
                    end else if (r_count == '0) begin
                        n_res.no_frame = 1'b1;
                        n_state        = S_EMIT;
                    end else begin
                        n_state = S_RING;
                    end
                end
            end
            S_RING: begin
                n_res.frame_no = ring_q;
                n_res.evicted  = 1'b1;
                n_head         = r_head + FRAME_W'(1);
                ring_wr_data   = ring_q;
                if (r_pinned) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    ring_wr_en = 1'b1;
                    n_tail     = r_tail + FRAME_W'(1);
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next_free <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_base      <= BASE_RESET;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_free <= n_next_free;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            if (cfg_wr && (paddr[2] == REG_FRAME_BASE)) begin
                r_base <= pwdata;
            end
            if ((r_state == S_EMIT) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pinned <= n_pinned;
        r_res    <= n_res;
        if ((r_state == S_EMIT) && out_free) begin
            r_out      <= r_res;
            r_o_victim <= r_res.evicted ? owner_q : '0;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_frame_no     = r_out.frame_no;
    assign o_evicted      = r_out.evicted;
    assign o_victim_owner = r_o_victim;
    assign o_no_frame     = r_out.no_frame;
    assign o_pte_index    = r_out.pte_index;
    assign o_pte_word     = r_out.pte_word;
    assign o_tlb_entry_hi = r_out.tlb_entry_hi;

endmodule

// ----- dv/tb_page_frame_allocator_fifo_unit.sv -----
`timescale 1ns / 100ps
// Testbench for page_frame_allocator_fifo_unit: a directed table, then random allocate and bind
// traffic checked against an in-bench frame manager model, with random sender and receiver gaps.
// Depends on pfa_pkg and the design sources of the block.
module tb_page_frame_allocator_fifo_unit;
    import pfa_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int N_DIR = 16;
    localparam int SEGMENT_ITEMS = 488;
    localparam logic [PADDR_W-1:0] FRAME_BASE_ADDR = PADDR_W'({REG_FRAME_BASE, 2'b00});

    typedef struct packed {
        logic                  action;
        logic                  pinned;
        logic [SEL_W-1:0]      frame_sel;
        logic [ADDR_W-1:0]     virt_addr;
        logic [OWNER_W-1:0]    owner_id;
        logic [FLAGS_W-1:0]    pte_flags;
    } t_frame_req;

    typedef struct packed {
        logic [FRAME_W-1:0]    frame_no;
        logic                  evicted;
        logic [OWNER_W-1:0]    victim_owner;
        logic                  no_frame;
        logic [VPN_W-1:0]      pte_index;
        logic [PTE_WORD_W-1:0] pte_word;
        logic [ADDR_W-1:0]     tlb_entry_hi;
    } t_frame_result;

    typedef enum logic {PLAN_SEND, PLAN_BASE} t_plan_kind;

    typedef struct packed {
        t_plan_kind    kind;
        t_frame_req    req;
        logic [31:0]   base;
        logic          typed;
        t_frame_result exp;
    } t_plan_row;

    localparam t_frame_req    NO_REQ = '0;
    localparam t_frame_result NO_RES = '0;

    localparam t_plan_row DIRECTED_PLAN [N_DIR] = '{
        '{PLAN_SEND, '{ACT_ALLOC, 1'b0, 6'h00, 32'h0000_0000, 12'h000, 6'h00}, 32'h0, 1'b1,
          '{6'd0, 1'b0, 12'h000, 1'b0, 20'h00000, 26'h0000000, 32'h0000_0000}},
        '{PLAN_SEND, '{ACT_ALLOC, 1'b1, 6'h3F, 32'hFFFF_FFFF, 12'hFFF, 6'h3F}, 32'h0, 1'b1,
          '{6'd1, 1'b0, 12'h000, 1'b0, 20'h00000, 26'h0000000, 32'h0000_0000}},
        '{PLAN_SEND, '{ACT_BIND, 1'b0, 6'd0, 32'hFFFF_FFFF, 12'hFFF, 6'h3F}, 32'h0, 1'b0, NO_RES},
        '{PLAN_SEND, '{ACT_BIND, 1'b1, 6'd63, 32'h0000_0000, 12'h000, 6'h00}, 32'h0, 1'b0, NO_RES},
        '{PLAN_SEND, '{ACT_BIND, 1'b0, 6'd1, 32'h1234_5FFF, 12'h800, 6'h15}, 32'h0, 1'b0, NO_RES},
        '{PLAN_BASE, NO_REQ, 32'h0000_0000, 1'b0, NO_RES},
        '{PLAN_SEND, '{ACT_BIND, 1'b0, 6'd63, 32'hFFFF_F000, 12'hABC, 6'h3F}, 32'h0, 1'b1,
          '{6'd63, 1'b0, 12'h000, 1'b0, 20'hFFFFF, 26'h0000FFF, 32'hFFFF_FABC}},
        '{PLAN_SEND, '{ACT_BIND, 1'b0, 6'd0, 32'h0000_0FFF, 12'h001, 6'h00}, 32'h0, 1'b1,
          '{6'd0, 1'b0, 12'h000, 1'b0, 20'h00000, 26'h0000000, 32'h0000_0001}},
        '{PLAN_BASE, NO_REQ, 32'hFFFF_FFFF, 1'b0, NO_RES},
        '{PLAN_SEND, '{ACT_BIND, 1'b0, 6'd1, 32'hFFFF_FFFF, 12'hFFF, 6'h00}, 32'h0, 1'b0, NO_RES},
        '{PLAN_SEND, '{ACT_BIND, 1'b0, 6'd63, 32'h8000_0000, 12'h000, 6'h2A}, 32'h0, 1'b0, NO_RES},
        '{PLAN_BASE, NO_REQ, BASE_RESET, 1'b0, NO_RES},
        '{PLAN_SEND, '{ACT_ALLOC, 1'b0, 6'h2A, 32'hDEAD_B000, 12'h5A5, 6'h15}, 32'h0, 1'b1,
          '{6'd2, 1'b0, 12'h000, 1'b0, 20'h00000, 26'h0000000, 32'h0000_0000}},
        '{PLAN_SEND, '{ACT_BIND, 1'b0, 6'd2, 32'h0040_0000, 12'h5A5, 6'h21}, 32'h0, 1'b0, NO_RES},
        '{PLAN_SEND, '{ACT_ALLOC, 1'b0, 6'h15, 32'h0000_1000, 12'h0FF, 6'h2A}, 32'h0, 1'b1,
          '{6'd3, 1'b0, 12'h000, 1'b0, 20'h00000, 26'h0000000, 32'h0000_0000}},
        '{PLAN_SEND, '{ACT_BIND, 1'b0, 6'd3, 32'h7FFF_E123, 12'h3C3, 6'h0C}, 32'h0, 1'b0, NO_RES}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_action = ACT_ALLOC;
    logic                  i_pinned = 1'b0;
    logic [SEL_W-1:0]      i_frame_sel = '0;
    logic [ADDR_W-1:0]     i_virt_addr = '0;
    logic [OWNER_W-1:0]    i_owner_id = '0;
    logic [FLAGS_W-1:0]    i_pte_flags = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [FRAME_W-1:0]    o_frame_no;
    logic                  o_evicted;
    logic [OWNER_W-1:0]    o_victim_owner;
    logic                  o_no_frame;
    logic [VPN_W-1:0]      o_pte_index;
    logic [PTE_WORD_W-1:0] o_pte_word;
    logic [ADDR_W-1:0]     o_tlb_entry_hi;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    logic [ADDR_W-1:0]  frame_base = BASE_RESET;
    bit                 frame_used [NUM_FRAMES];
    logic [OWNER_W-1:0] owner_tab [NUM_FRAMES];
    bit                 owner_known [NUM_FRAMES];
    logic [FRAME_W-1:0] ring_slot [NUM_FRAMES];
    int                 ring_head = 0;
    int                 ring_tail = 0;
    int                 ring_count = 0;
    int                 used_count = 0;
    int                 no_frame_total = 0;
    int                 unbound_frames [$];

    t_frame_result pending_results [$];
    t_frame_result got;
    t_frame_result want;
    int            mismatch_count = 0;
    int            stall_left = 0;
    bit            tx_quiet = 1'b0;
    bit            rx_quiet = 1'b0;
    int unsigned   cycle_count = 0;

    page_frame_allocator_fifo_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_pinned       (i_pinned),
        .i_frame_sel    (i_frame_sel),
        .i_virt_addr    (i_virt_addr),
        .i_owner_id     (i_owner_id),
        .i_pte_flags    (i_pte_flags),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_frame_no     (o_frame_no),
        .o_evicted      (o_evicted),
        .o_victim_owner (o_victim_owner),
        .o_no_frame     (o_no_frame),
        .o_pte_index    (o_pte_index),
        .o_pte_word     (o_pte_word),
        .o_tlb_entry_hi (o_tlb_entry_hi),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] seen,
                                   input logic [31:0] wanted);
        $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, seen, wanted);
        mismatch_count++;
    endtask

    function automatic t_frame_result manage_frame(input t_frame_req req);
        t_frame_result     res;
        logic [ADDR_W-1:0] paddr_calc;
        int                pick;
        bit                found;
        res = '0;
        pick = 0;
        found = 1'b0;
        if (req.action == ACT_ALLOC) begin
            for (int f = 0; f < NUM_FRAMES; f++) begin
                if (!found && !frame_used[f]) begin
                    pick = f;
                    found = 1'b1;
                end
            end
            if (!found) begin
                if (ring_count == 0) begin
                    res.no_frame = 1'b1;
                    no_frame_total++;
                end else begin
                    pick = int'(ring_slot[ring_head]);
                    ring_head = (ring_head + 1) % NUM_FRAMES;
                    ring_count--;
                    res.evicted = 1'b1;
                    res.victim_owner = owner_tab[pick];
                    found = 1'b1;
                end
            end
            if (found) begin
                if (!frame_used[pick]) begin
                    used_count++;
                end
                frame_used[pick] = 1'b1;
                if (!owner_known[pick]) begin
                    unbound_frames.push_back(pick);
                end
                if (!req.pinned && ring_count < NUM_FRAMES) begin
                    ring_slot[ring_tail] = FRAME_W'(pick);
                    ring_tail = (ring_tail + 1) % NUM_FRAMES;
                    ring_count++;
                end
                res.frame_no = FRAME_W'(pick);
            end
        end else begin
            paddr_calc = frame_base + (ADDR_W'(req.frame_sel) << PAGE_SHIFT);
            owner_tab[req.frame_sel] = req.owner_id;
            owner_known[req.frame_sel] = 1'b1;
            res.frame_no = req.frame_sel;
            res.pte_index = req.virt_addr[ADDR_W-1:PAGE_SHIFT];
            res.pte_word = {paddr_calc[ADDR_W-1:PAGE_SHIFT], req.pte_flags};
            res.tlb_entry_hi = {req.virt_addr[ADDR_W-1:PAGE_SHIFT], req.owner_id};
        end
        return res;
    endfunction

    // Frames are never freed, so evicting a frame whose owner was never bound must be
    // avoided: such an allocation is turned into a bind of the frame at the ring head.
    function automatic t_frame_req next_request(input bit draining);
        t_frame_req req;
        req.action = ACT_ALLOC;
        req.pinned = 1'($urandom);
        req.frame_sel = SEL_W'($urandom);
        req.virt_addr = $urandom;
        req.owner_id = OWNER_W'($urandom);
        req.pte_flags = FLAGS_W'($urandom);
        if ($urandom_range(0, 99) < (draining ? 15 : 45)) begin
            req.action = ACT_BIND;
            if (unbound_frames.size() != 0 && $urandom_range(0, 2) != 0) begin
                req.frame_sel = SEL_W'(unbound_frames.pop_front());
            end
        end else if (draining) begin
            req.pinned = (ring_count != 0) || ($urandom_range(0, 1) != 0);
        end else if (used_count < NUM_FRAMES) begin
            req.pinned = ($urandom_range(0, 7) == 0);
        end else begin
            req.pinned = (ring_count > 24) && ($urandom_range(0, 9) == 0);
        end
        if (req.action == ACT_ALLOC && used_count == NUM_FRAMES && ring_count != 0
                && !owner_known[ring_slot[ring_head]]) begin
            req.action = ACT_BIND;
            req.frame_sel = ring_slot[ring_head];
        end
        return req;
    endfunction

    task automatic send_request(input t_frame_req req, input logic typed,
                                input t_frame_result typed_exp);
        t_frame_result predicted;
        int            gap;
        if ($urandom_range(0, 63) == 0) begin
            tx_quiet = !tx_quiet;
        end
        gap = tx_quiet ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= req.action;
        i_pinned <= req.pinned;
        i_frame_sel <= req.frame_sel;
        i_virt_addr <= req.virt_addr;
        i_owner_id <= req.owner_id;
        i_pte_flags <= req.pte_flags;
        do @(posedge i_clk); while (o_stall);
        predicted = manage_frame(req);
        pending_results.push_back(typed ? typed_exp : predicted);
    endtask

    task automatic apb_transfer(input logic is_write, input logic [PADDR_W-1:0] addr,
                                input logic [31:0] data, output logic [31:0] rdata);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_frame_base(input logic [31:0] value);
        logic [31:0] readback;
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        apb_transfer(1'b1, FRAME_BASE_ADDR, value, readback);
        frame_base = value;
        apb_transfer(1'b0, FRAME_BASE_ADDR, 32'h0, readback);
        if (readback !== frame_base) begin
            report_mismatch("frame_base_addr readback", readback, frame_base);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got.frame_no = o_frame_no;
            got.evicted = o_evicted;
            got.victim_owner = o_victim_owner;
            got.no_frame = o_no_frame;
            got.pte_index = o_pte_index;
            got.pte_word = o_pte_word;
            got.tlb_entry_hi = o_tlb_entry_hi;
            if (pending_results.size() == 0) begin
                report_mismatch("transaction with nothing pending", got.tlb_entry_hi, 32'h0);
            end else begin
                want = pending_results.pop_front();
                if (got.frame_no !== want.frame_no)
                    report_mismatch("frame_no", 32'(got.frame_no), 32'(want.frame_no));
                if (got.evicted !== want.evicted)
                    report_mismatch("evicted", 32'(got.evicted), 32'(want.evicted));
                if (got.victim_owner !== want.victim_owner)
                    report_mismatch("victim_owner", 32'(got.victim_owner),
                                    32'(want.victim_owner));
                if (got.no_frame !== want.no_frame)
                    report_mismatch("no_frame", 32'(got.no_frame), 32'(want.no_frame));
                if (got.pte_index !== want.pte_index)
                    report_mismatch("pte_index", 32'(got.pte_index), 32'(want.pte_index));
                if (got.pte_word !== want.pte_word)
                    report_mismatch("pte_word", 32'(got.pte_word), 32'(want.pte_word));
                if (got.tlb_entry_hi !== want.tlb_entry_hi)
                    report_mismatch("tlb_entry_hi", got.tlb_entry_hi, want.tlb_entry_hi);
            end
            if ($urandom_range(0, 49) == 0) begin
                rx_quiet = !rx_quiet;
            end
            stall_left = rx_quiet ? 0 : $urandom_range(0, 3);
            i_stall <= (stall_left != 0);
        end else if (o_valid && i_stall) begin
            stall_left--;
            if (stall_left <= 0) begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        logic [31:0] readback;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        apb_transfer(1'b0, FRAME_BASE_ADDR, 32'h0, readback);
        if (readback !== BASE_RESET) begin
            report_mismatch("frame_base_addr after reset", readback, BASE_RESET);
        end
        for (int n = 0; n < N_DIR; n++) begin
            if (DIRECTED_PLAN[n].kind == PLAN_BASE) begin
                set_frame_base(DIRECTED_PLAN[n].base);
            end else begin
                send_request(DIRECTED_PLAN[n].req, DIRECTED_PLAN[n].typed,
                             DIRECTED_PLAN[n].exp);
            end
        end
        for (int seg = 0; seg < 4; seg++) begin
            set_frame_base(seg == 3 ? BASE_RESET : $urandom);
            repeat (SEGMENT_ITEMS) send_request(next_request(1'b0), 1'b0, NO_RES);
        end
        // Pinned allocations empty the replacement ring until nothing is left to evict.
        while (no_frame_total < 12) begin
            send_request(next_request(1'b1), 1'b0, NO_RES);
        end
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/pfa_pkg.sv
design/pfa_ram.sv
design/page_frame_allocator_fifo_unit.sv
dv/tb_page_frame_allocator_fifo_unit.sv
